FILE: src/pdst_pkg.sv
// Shared types, constants and register map of the position drive controller.
package pdst_pkg;

  localparam int unsigned GAIN_FRAC_BITS_DEF = 8;
  localparam int unsigned ERROR_BITS_DEF     = 24;

  localparam int unsigned ENC_BITS     = 24;
  localparam int unsigned GAIN_BITS    = 10;
  localparam int unsigned LIMIT_BITS   = 7;
  localparam int unsigned ZONE_BITS    = 16;
  localparam int unsigned TIMER_BITS   = 16;
  localparam int unsigned THRESH_BITS  = 16;
  localparam int unsigned ELAPSED_BITS = 8;
  localparam int unsigned INTEG_BITS   = 32;
  localparam int unsigned POWER_BITS   = 8;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam logic [TIMER_BITS-1:0] MIN_SETTLE_MS = 16'd250;

  typedef enum logic [2:0] {
    REG_TARGET_TICKS     = 3'd0,
    REG_GAIN_P           = 3'd1,
    REG_GAIN_I           = 3'd2,
    REG_GAIN_D           = 3'd3,
    REG_POWER_LIMIT      = 3'd4,
    REG_INTEGRAL_ZONE    = 3'd5,
    REG_SETTLE_TIME_MS   = 3'd6,
    REG_SETTLE_THRESHOLD = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [ENC_BITS-1:0]    target_ticks;
    logic [GAIN_BITS-1:0]   gain_p;
    logic [GAIN_BITS-1:0]   gain_i;
    logic [GAIN_BITS-1:0]   gain_d;
    logic [LIMIT_BITS-1:0]  power_limit;
    logic [ZONE_BITS-1:0]   integral_zone;
    logic [TIMER_BITS-1:0]  settle_time_ms;
    logic [THRESH_BITS-1:0] settle_threshold;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    target_ticks:     24'd0,
    gain_p:           10'd67,
    gain_i:           10'd13,
    gain_d:           10'd159,
    power_limit:      7'd127,
    integral_zone:    16'd299,
    settle_time_ms:   16'd250,
    settle_threshold: 16'd30
  };

  // stage load strobes, one per pipeline register bank after the input register
  typedef struct packed {
    logic ld_s2;
    logic ld_s3;
    logic ld_s4;
    logic ld_out;
  } pipe_ctrl_t;

endpackage

FILE: src/pid_position_drive_with_settle_timer_core.sv
// Top level of the position drive PID controller with integral zone and settle timer.
// One control tick is accepted per clock cycle while in_ready_o is high, and its result
// reaches the output register through the input register, state stage, product stage
// and sum stage, so the block sustains one tick per cycle when the output side keeps
// taking results. Throughput is set by the move state loop (integral, previous error,
// settle timer and flags), which closes within the first stage; the gain
// multiplications and the Q sum run in later stages. A stalled output
// backs the pipeline up one stage at a time, and ready drops only once every stage is
// full. No clearing pass after reset.
module pid_position_drive_with_settle_timer_core #(
  parameter int unsigned ERROR_BITS     = pdst_pkg::ERROR_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = pdst_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    mode_i,
  input  logic signed [pdst_pkg::ENC_BITS-1:0]    encoder_count_i,
  input  logic [pdst_pkg::ELAPSED_BITS-1:0]       elapsed_ms_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [pdst_pkg::POWER_BITS-1:0]  drive_power_o,
  output logic                                    done_res_o,
  output logic signed [ERROR_BITS-1:0]            error_value_o,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [pdst_pkg::APB_AW-1:0]             paddr,
  input  logic [pdst_pkg::APB_DW-1:0]             pwdata,
  output logic [pdst_pkg::APB_DW-1:0]             prdata,
  output logic                                    pready
);

  pdst_pkg::cfg_t       cfg;
  pdst_pkg::pipe_ctrl_t ctrl;

  logic                                  mode_s1_q;
  logic signed [pdst_pkg::ENC_BITS-1:0]  count_s1_q;
  logic [pdst_pkg::ELAPSED_BITS-1:0]     elapsed_s1_q;

  logic v1_q, v2_q, v3_q, v4_q, vout_q;
  logic mv1, mv2, mv3, mv4, free2, free3, free4, free_out, in_fire;

  logic signed [ERROR_BITS-1:0]           err;
  logic signed [pdst_pkg::INTEG_BITS-1:0] integ;
  logic signed [ERROR_BITS:0]             deriv;
  logic                                   done;

  // a stage moves on when the one after it is empty or moving
  assign free_out   = !vout_q | out_ready_i;
  assign mv4        = v4_q & free_out;
  assign free4      = !v4_q | mv4;
  assign mv3        = v3_q & free4;
  assign free3      = !v3_q | mv3;
  assign mv2        = v2_q & free3;
  assign free2      = !v2_q | mv2;
  assign mv1        = v1_q & free2;
  assign in_ready_o = !v1_q | mv1;
  assign in_fire    = in_valid_i & in_ready_o;

  assign ctrl.ld_s2  = mv1;
  assign ctrl.ld_s3  = mv2;
  assign ctrl.ld_s4  = mv3;
  assign ctrl.ld_out = mv4;

  assign out_valid_o = vout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      v1_q   <= in_fire | (v1_q & !mv1);
      v2_q   <= mv1 | (v2_q & !mv2);
      v3_q   <= mv2 | (v3_q & !mv3);
      v4_q   <= mv3 | (v4_q & !mv4);
      vout_q <= mv4 | (vout_q & !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_s1_q    <= mode_i;
      count_s1_q   <= encoder_count_i;
      elapsed_s1_q <= elapsed_ms_i;
    end
  end

  pdst_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pdst_move_state #(
    .ERROR_BITS (ERROR_BITS)
  ) u_move_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (mv1),
    .mode_i    (mode_s1_q),
    .count_i   (count_s1_q),
    .elapsed_i (elapsed_s1_q),
    .cfg_i     (cfg),
    .err_o     (err),
    .integ_o   (integ),
    .deriv_o   (deriv),
    .done_o    (done)
  );

  pdst_pid_math #(
    .ERROR_BITS     (ERROR_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_pid_math (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg),
    .err_i         (err),
    .integ_i       (integ),
    .deriv_i       (deriv),
    .done_i        (done),
    .drive_power_o (drive_power_o),
    .done_o        (done_res_o),
    .error_o       (error_value_o)
  );

endmodule

FILE: src/pdst_cfg_regs.sv
// APB configuration register file of the position drive controller.
module pdst_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pdst_pkg::APB_AW-1:0]    paddr,
  input  logic [pdst_pkg::APB_DW-1:0]    pwdata,
  output logic [pdst_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output pdst_pkg::cfg_t                 cfg_o
);

  pdst_pkg::cfg_t     cfg_q, cfg_d;
  pdst_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = pdst_pkg::reg_idx_e'(paddr[pdst_pkg::APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        pdst_pkg::REG_TARGET_TICKS:
          cfg_d.target_ticks = pwdata[pdst_pkg::ENC_BITS-1:0];
        pdst_pkg::REG_GAIN_P:        cfg_d.gain_p = pwdata[pdst_pkg::GAIN_BITS-1:0];
        pdst_pkg::REG_GAIN_I:        cfg_d.gain_i = pwdata[pdst_pkg::GAIN_BITS-1:0];
        pdst_pkg::REG_GAIN_D:        cfg_d.gain_d = pwdata[pdst_pkg::GAIN_BITS-1:0];
        pdst_pkg::REG_POWER_LIMIT:
          cfg_d.power_limit = pwdata[pdst_pkg::LIMIT_BITS-1:0];
        pdst_pkg::REG_INTEGRAL_ZONE:
          cfg_d.integral_zone = pwdata[pdst_pkg::ZONE_BITS-1:0];
        pdst_pkg::REG_SETTLE_TIME_MS:
          cfg_d.settle_time_ms = pwdata[pdst_pkg::TIMER_BITS-1:0];
        pdst_pkg::REG_SETTLE_THRESHOLD:
          cfg_d.settle_threshold = pwdata[pdst_pkg::THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pdst_pkg::REG_TARGET_TICKS:
        prdata = pdst_pkg::APB_DW'($signed(cfg_q.target_ticks));
      pdst_pkg::REG_GAIN_P:         prdata = pdst_pkg::APB_DW'(cfg_q.gain_p);
      pdst_pkg::REG_GAIN_I:         prdata = pdst_pkg::APB_DW'(cfg_q.gain_i);
      pdst_pkg::REG_GAIN_D:         prdata = pdst_pkg::APB_DW'(cfg_q.gain_d);
      pdst_pkg::REG_POWER_LIMIT:    prdata = pdst_pkg::APB_DW'(cfg_q.power_limit);
      pdst_pkg::REG_INTEGRAL_ZONE:  prdata = pdst_pkg::APB_DW'(cfg_q.integral_zone);
      pdst_pkg::REG_SETTLE_TIME_MS: prdata = pdst_pkg::APB_DW'(cfg_q.settle_time_ms);
      pdst_pkg::REG_SETTLE_THRESHOLD:
        prdata = pdst_pkg::APB_DW'($signed(cfg_q.settle_threshold));
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= pdst_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: src/pdst_move_state.sv
// Error, integral zone, derivative and settle timer: the per-move state loop.
module pdst_move_state #(
  parameter int unsigned ERROR_BITS = pdst_pkg::ERROR_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    commit_i,
  input  logic                                    mode_i,
  input  logic signed [pdst_pkg::ENC_BITS-1:0]    count_i,
  input  logic [pdst_pkg::ELAPSED_BITS-1:0]       elapsed_i,
  input  pdst_pkg::cfg_t                          cfg_i,
  output logic signed [ERROR_BITS-1:0]            err_o,
  output logic signed [pdst_pkg::INTEG_BITS-1:0]  integ_o,
  output logic signed [ERROR_BITS:0]              deriv_o,
  output logic                                    done_o
);

  localparam int unsigned WIDE = 34;
  localparam int unsigned TB   = pdst_pkg::TIMER_BITS;
  localparam logic signed [WIDE-1:0] EMAX =
    WIDE'((longint'(1) <<< (ERROR_BITS - 1)) - longint'(1));
  localparam logic signed [WIDE-1:0] EMIN = -EMAX - WIDE'(1);
  localparam logic signed [WIDE-1:0] IMAX =
    WIDE'((longint'(1) <<< (pdst_pkg::INTEG_BITS - 1)) - longint'(1));
  localparam logic signed [WIDE-1:0] IMIN = -IMAX - WIDE'(1);

  logic signed [pdst_pkg::INTEG_BITS-1:0] integ_q, integ_d, integ_eff, integ_new;
  logic signed [ERROR_BITS-1:0]           prev_q, prev_d, prev_eff;
  logic                                   settled_q, settled_d, settled_eff, settled_new;
  logic [TB-1:0]                          timer_q, timer_d, timer_eff, timer_new, settle_lim;
  logic                                   fin_q, fin_d, fin_eff, fin_now;

  logic signed [WIDE-1:0] raw, err_w, mag, integ_sum, integ_sat, deriv_w;
  logic [TB:0]            timer_sum;
  logic                   in_zone;

  // a new move starts from cleared state
  assign integ_eff   = mode_i ? '0 : integ_q;
  assign prev_eff    = mode_i ? '0 : prev_q;
  assign settled_eff = mode_i ? 1'b0 : settled_q;
  assign timer_eff   = mode_i ? '0 : timer_q;
  assign fin_eff     = mode_i ? 1'b0 : fin_q;

  always_comb begin
    raw = WIDE'($signed(cfg_i.target_ticks)) - (WIDE'(count_i) <<< 1);
    if (raw > EMAX) begin
      err_w = EMAX;
    end else if (raw < EMIN) begin
      err_w = EMIN;
    end else begin
      err_w = raw;
    end
  end

  // settle timer, saturating
  assign timer_sum  = {1'b0, timer_eff} + (TB + 1)'(elapsed_i);
  assign timer_new  = !settled_eff ? timer_eff :
                      (timer_sum[TB] ? '1 : timer_sum[TB-1:0]);
  assign settle_lim = (cfg_i.settle_time_ms < pdst_pkg::MIN_SETTLE_MS) ?
                      pdst_pkg::MIN_SETTLE_MS : cfg_i.settle_time_ms;
  assign fin_now    = fin_eff | (settled_eff & (timer_new >= settle_lim));

  // integral zone
  assign mag       = (err_w < 0) ? -err_w : err_w;
  assign in_zone   = (err_w != '0) && ($unsigned(mag) < WIDE'(cfg_i.integral_zone));
  assign integ_sum = WIDE'(integ_eff) + err_w;
  assign integ_sat = (integ_sum > IMAX) ? IMAX : ((integ_sum < IMIN) ? IMIN : integ_sum);
  assign integ_new = in_zone ? integ_sat[pdst_pkg::INTEG_BITS-1:0] : '0;

  assign deriv_w     = (err_w == '0) ? '0 : err_w - WIDE'(prev_eff);
  assign settled_new = settled_eff |
                       (err_w < WIDE'($signed(cfg_i.settle_threshold)));

  always_comb begin
    integ_d   = integ_eff;
    prev_d    = prev_eff;
    settled_d = settled_eff;
    timer_d   = timer_eff;
    fin_d     = fin_eff;
    if (!fin_eff) begin
      timer_d = timer_new;
      if (fin_now) begin
        fin_d = 1'b1;
      end else begin
        integ_d   = integ_new;
        prev_d    = err_w[ERROR_BITS-1:0];
        settled_d = settled_new;
        if (!settled_new) begin
          timer_d = '0;
        end
      end
    end
  end

  assign err_o   = err_w[ERROR_BITS-1:0];
  assign integ_o = integ_new;
  assign deriv_o = deriv_w[ERROR_BITS:0];
  assign done_o  = fin_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= '0;
      prev_q    <= '0;
      settled_q <= 1'b0;
      timer_q   <= '0;
      fin_q     <= 1'b0;
    end else if (commit_i) begin
      integ_q   <= integ_d;
      prev_q    <= prev_d;
      settled_q <= settled_d;
      timer_q   <= timer_d;
      fin_q     <= fin_d;
    end
  end

endmodule

FILE: src/pdst_pid_math.sv
// PID datapath: gain products, Q sum, truncation toward zero and power clamp.
module pdst_pid_math #(
  parameter int unsigned ERROR_BITS     = pdst_pkg::ERROR_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = pdst_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  pdst_pkg::pipe_ctrl_t                    ctrl_i,
  input  pdst_pkg::cfg_t                          cfg_i,
  input  logic signed [ERROR_BITS-1:0]            err_i,
  input  logic signed [pdst_pkg::INTEG_BITS-1:0]  integ_i,
  input  logic signed [ERROR_BITS:0]              deriv_i,
  input  logic                                    done_i,
  output logic signed [pdst_pkg::POWER_BITS-1:0]  drive_power_o,
  output logic                                    done_o,
  output logic signed [ERROR_BITS-1:0]            error_o
);

  localparam int unsigned GW    = pdst_pkg::GAIN_BITS + 1;
  localparam int unsigned PP_W  = ERROR_BITS + GW;
  localparam int unsigned PI_W  = pdst_pkg::INTEG_BITS + GW;
  localparam int unsigned PD_W  = ERROR_BITS + 1 + GW;
  localparam int unsigned SUM_W = ((PD_W > PI_W) ? PD_W : PI_W) + 2;
  localparam int unsigned Q_W   = SUM_W - GAIN_FRAC_BITS;

  // stage 2
  logic signed [ERROR_BITS-1:0]           err_s2_q;
  logic signed [pdst_pkg::INTEG_BITS-1:0] integ_s2_q;
  logic signed [ERROR_BITS:0]             deriv_s2_q;
  logic                                   done_s2_q;
  logic signed [GW-1:0]                   gp, gi, gd;
  logic signed [PP_W-1:0]                 pp;
  logic signed [PI_W-1:0]                 pi;
  logic signed [PD_W-1:0]                 pd;

  // stage 3
  logic signed [PP_W-1:0]       pp_s3_q;
  logic signed [PI_W-1:0]       pi_s3_q;
  logic signed [PD_W-1:0]       pd_s3_q;
  logic signed [ERROR_BITS-1:0] err_s3_q;
  logic                         done_s3_q;
  logic signed [SUM_W-1:0]      sum;

  // stage 4
  logic signed [SUM_W-1:0]      sum_s4_q;
  logic signed [ERROR_BITS-1:0] err_s4_q;
  logic                         done_s4_q;
  logic signed [Q_W-1:0]        q_trunc, q, lim;
  logic                         round_up;
  logic signed [Q_W-1:0]        power_w;

  // output register
  logic signed [pdst_pkg::POWER_BITS-1:0] power_q;
  logic                                   done_q;
  logic signed [ERROR_BITS-1:0]           error_q;

  assign gp = $signed({1'b0, cfg_i.gain_p});
  assign gi = $signed({1'b0, cfg_i.gain_i});
  assign gd = $signed({1'b0, cfg_i.gain_d});
  assign pp = PP_W'(gp) * PP_W'(err_s2_q);
  assign pi = PI_W'(gi) * PI_W'(integ_s2_q);
  assign pd = PD_W'(gd) * PD_W'(deriv_s2_q);

  assign sum = SUM_W'(pp_s3_q) + SUM_W'(pi_s3_q) + SUM_W'(pd_s3_q);

  // shift then bump negatives with dropped bits: truncation toward zero
  assign q_trunc  = sum_s4_q[SUM_W-1:GAIN_FRAC_BITS];
  assign round_up = sum_s4_q[SUM_W-1] & (|sum_s4_q[GAIN_FRAC_BITS-1:0]);
  assign q        = q_trunc + Q_W'(round_up);
  assign lim      = Q_W'($signed({1'b0, cfg_i.power_limit}));

  always_comb begin
    if (q > lim) begin
      power_w = lim;
    end else if (q < -lim) begin
      power_w = -lim;
    end else begin
      power_w = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_s2) begin
      err_s2_q   <= err_i;
      integ_s2_q <= integ_i;
      deriv_s2_q <= deriv_i;
      done_s2_q  <= done_i;
    end
    if (ctrl_i.ld_s3) begin
      pp_s3_q   <= pp;
      pi_s3_q   <= pi;
      pd_s3_q   <= pd;
      err_s3_q  <= err_s2_q;
      done_s3_q <= done_s2_q;
    end
    if (ctrl_i.ld_s4) begin
      sum_s4_q  <= sum;
      err_s4_q  <= err_s3_q;
      done_s4_q <= done_s3_q;
    end
    if (ctrl_i.ld_out) begin
      power_q <= done_s4_q ? '0 : power_w[pdst_pkg::POWER_BITS-1:0];
      done_q  <= done_s4_q;
      error_q <= err_s4_q;
    end
  end

  assign drive_power_o = power_q;
  assign done_o        = done_q;
  assign error_o       = error_q;

endmodule

FILE: src/pdst_checker.sv
// Port-level assertions of the position drive controller and their bind.
module pdst_checker #(
  parameter int unsigned ERROR_BITS = pdst_pkg::ERROR_BITS_DEF
) (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_ready_o,
  input logic                                    out_valid_o,
  input logic                                    out_ready_i,
  input logic signed [pdst_pkg::POWER_BITS-1:0]  drive_power_o,
  input logic                                    done_res_o,
  input logic signed [ERROR_BITS-1:0]            error_value_o
);

  localparam logic [pdst_pkg::POWER_BITS-1:0] POWER_MOST_NEG =
    {1'b1, {(pdst_pkg::POWER_BITS-1){1'b0}}};

  // a finished move drives no power
  a_done_no_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> drive_power_o == '0)
    else $error("power nonzero on a finished move");

  // the clamp is symmetric, so the most negative code never shows
  a_power_symmetric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_power_o != POWER_MOST_NEG)
    else $error("power below the negative clamp");

  // the pipeline only refuses a request when the output side is stalled
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready while output flows");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_power_o) &&
      $stable(done_res_o) && $stable(error_value_o))
    else $error("stalled result changed or dropped");

endmodule

bind pid_position_drive_with_settle_timer_core pdst_checker #(
  .ERROR_BITS (ERROR_BITS)
) u_pdst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .drive_power_o (drive_power_o),
  .done_res_o    (done_res_o),
  .error_value_o (error_value_o)
);

FILE: tb/sv/pid_position_drive_with_settle_timer_core_tb.sv
// Self-checking testbench for the position drive PID controller with settle timer.
module pid_position_drive_with_settle_timer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EW = pdst_pkg::ERROR_BITS_DEF;
  localparam int FRAC = pdst_pkg::GAIN_FRAC_BITS_DEF;
  localparam int PW = pdst_pkg::POWER_BITS;
  localparam int CW = pdst_pkg::ENC_BITS;
  localparam int MW = pdst_pkg::ELAPSED_BITS;
  localparam int AW = pdst_pkg::APB_AW;
  localparam int DW = pdst_pkg::APB_DW;
  localparam longint ERR_MAX = (longint'(1) << (EW - 1)) - 1;
  localparam longint ERR_MIN = -ERR_MAX - 1;
  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;
  localparam longint TIMER_MAX = 65535;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_CAP = 200;

  typedef struct {
    logic signed [PW-1:0] power;
    logic                 done;
    logic signed [EW-1:0] err;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  mode_i = 1'b0;
  logic signed [CW-1:0]  encoder_count_i = '0;
  logic [MW-1:0]         elapsed_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic signed [PW-1:0]  drive_power_o;
  logic                  done_res_o;
  logic signed [EW-1:0]  error_value_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [AW-1:0]         paddr = '0;
  logic [DW-1:0]         pwdata = '0;
  logic [DW-1:0]         prdata;
  logic                  pready;

  pid_position_drive_with_settle_timer_core #(
    .ERROR_BITS     (EW),
    .GAIN_FRAC_BITS (FRAC)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .encoder_count_i (encoder_count_i),
    .elapsed_ms_i    (elapsed_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_power_o   (drive_power_o),
    .done_res_o      (done_res_o),
    .error_value_o   (error_value_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the register file and of the move state
  pdst_pkg::cfg_t cfg_shadow = pdst_pkg::CFG_RESET;
  longint integ_acc = 0;
  longint last_err = 0;
  bit     settled = 1'b0;
  longint settle_ms_count = 0;
  bit     move_done = 1'b0;

  tick_result_t expected_ticks[$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  stall_len = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;

  function automatic tick_result_t predict_tick(logic m, logic signed [CW-1:0] cnt,
                                                logic [MW-1:0] ms);
    tick_result_t r;
    longint err, mag, deriv, sum, q, lim, pwr;
    if (m) begin
      integ_acc = 0;
      last_err = 0;
      settled = 1'b0;
      settle_ms_count = 0;
      move_done = 1'b0;
    end
    err = longint'($signed(cfg_shadow.target_ticks)) - 2 * longint'(cnt);
    if (err > ERR_MAX) err = ERR_MAX;
    if (err < ERR_MIN) err = ERR_MIN;
    pwr = 0;
    if (!move_done) begin
      if (settled) begin
        settle_ms_count = settle_ms_count + longint'(ms);
        if (settle_ms_count > TIMER_MAX) settle_ms_count = TIMER_MAX;
      end
      lim = longint'(cfg_shadow.settle_time_ms);
      if (lim < longint'(pdst_pkg::MIN_SETTLE_MS)) lim = longint'(pdst_pkg::MIN_SETTLE_MS);
      if (settled && settle_ms_count >= lim) move_done = 1'b1;
    end
    if (!move_done) begin
      mag = (err < 0) ? -err : err;
      if (err != 0 && mag < longint'(cfg_shadow.integral_zone)) begin
        integ_acc = integ_acc + err;
        if (integ_acc > INTEG_MAX) integ_acc = INTEG_MAX;
        if (integ_acc < INTEG_MIN) integ_acc = INTEG_MIN;
      end else begin
        integ_acc = 0;
      end
      deriv = (err == 0) ? 0 : err - last_err;
      last_err = err;
      sum = longint'(cfg_shadow.gain_p) * err + longint'(cfg_shadow.gain_i) * integ_acc
            + longint'(cfg_shadow.gain_d) * deriv;
      // signed division truncates toward zero
      q = sum / (longint'(1) << FRAC);
      lim = longint'(cfg_shadow.power_limit);
      pwr = (q > lim) ? lim : ((q < -lim) ? -lim : q);
      if (err < longint'($signed(cfg_shadow.settle_threshold))) settled = 1'b1;
      if (!settled) settle_ms_count = 0;
    end
    r.power = pwr[PW-1:0];
    r.done = move_done;
    r.err = err[EW-1:0];
    return r;
  endfunction

  // predict on each accepted request, then check each accepted result
  always @(posedge clk) begin
    tick_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        expected_ticks.push_back(predict_tick(mode_i, encoder_count_i, elapsed_ms_i));
      if (out_valid_o && out_ready_i) begin
        if (expected_ticks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP) $error("result with no request pending");
        end else begin
          want = expected_ticks.pop_front();
          if (drive_power_o !== want.power) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
              $error("drive_power: expected %0d, got %0d", want.power, drive_power_o);
          end
          if (done_res_o !== want.done) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
              $error("done_res: expected %0d, got %0d", want.done, done_res_o);
          end
          if (error_value_o !== want.err) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
              $error("error_value: expected %0d, got %0d", want.err, error_value_o);
          end
        end
      end
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_len > 0) begin
      out_ready_i <= 1'b0;
      stall_len = stall_len - 1;
    end else begin
      out_ready_i <= rx_steady || ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // all tasks are entered and left just after a rising edge
  // random gaps before a few requests keep the sender idle about 17% of the time
  task automatic send_tick(logic m, logic [CW-1:0] cnt, logic [MW-1:0] ms);
    if (!tx_steady && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      encoder_count_i <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    encoder_count_i <= cnt;
    elapsed_ms_i <= ms;
    do @(posedge clk); while (!in_ready_o);
  endtask

  task automatic send_noise();
    send_tick($urandom_range(9) == 0, $urandom, $urandom_range(255));
  endtask

  // let the pending edge pass first so the last accepted request is already queued
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write a register, update the shadow, then read it back
  task automatic apb_write(pdst_pkg::reg_idx_e idx, logic [DW-1:0] v);
    int w;
    logic [DW-1:0] mask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AW'({idx, 2'b00});
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      pdst_pkg::REG_TARGET_TICKS: begin
        cfg_shadow.target_ticks = v[pdst_pkg::ENC_BITS-1:0];
        w = pdst_pkg::ENC_BITS;
      end
      pdst_pkg::REG_GAIN_P: begin
        cfg_shadow.gain_p = v[pdst_pkg::GAIN_BITS-1:0];
        w = pdst_pkg::GAIN_BITS;
      end
      pdst_pkg::REG_GAIN_I: begin
        cfg_shadow.gain_i = v[pdst_pkg::GAIN_BITS-1:0];
        w = pdst_pkg::GAIN_BITS;
      end
      pdst_pkg::REG_GAIN_D: begin
        cfg_shadow.gain_d = v[pdst_pkg::GAIN_BITS-1:0];
        w = pdst_pkg::GAIN_BITS;
      end
      pdst_pkg::REG_POWER_LIMIT: begin
        cfg_shadow.power_limit = v[pdst_pkg::LIMIT_BITS-1:0];
        w = pdst_pkg::LIMIT_BITS;
      end
      pdst_pkg::REG_INTEGRAL_ZONE: begin
        cfg_shadow.integral_zone = v[pdst_pkg::ZONE_BITS-1:0];
        w = pdst_pkg::ZONE_BITS;
      end
      pdst_pkg::REG_SETTLE_TIME_MS: begin
        cfg_shadow.settle_time_ms = v[pdst_pkg::TIMER_BITS-1:0];
        w = pdst_pkg::TIMER_BITS;
      end
      default: begin
        cfg_shadow.settle_threshold = v[pdst_pkg::THRESH_BITS-1:0];
        w = pdst_pkg::THRESH_BITS;
      end
    endcase
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    mask = (DW'(1) << w) - 1;
    if ((prdata & mask) !== (v & mask)) begin
      mismatch_count++;
      $error("prdata: expected %0h, got %0h", v & mask, prdata & mask);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(int tgt, int kp, int ki, int kd, int plim, int zone,
                           int settle_ms, int thresh);
    apb_write(pdst_pkg::REG_TARGET_TICKS, tgt);
    apb_write(pdst_pkg::REG_GAIN_P, kp);
    apb_write(pdst_pkg::REG_GAIN_I, ki);
    apb_write(pdst_pkg::REG_GAIN_D, kd);
    apb_write(pdst_pkg::REG_POWER_LIMIT, plim);
    apb_write(pdst_pkg::REG_INTEGRAL_ZONE, zone);
    apb_write(pdst_pkg::REG_SETTLE_TIME_MS, settle_ms);
    apb_write(pdst_pkg::REG_SETTLE_THRESHOLD, thresh);
  endtask

  // a move: start, ramp toward half the target, then hover around it
  task automatic drive_move(int len);
    longint half, cnt;
    int ramp;
    half = longint'($signed(cfg_shadow.target_ticks)) / 2;
    ramp = $urandom_range(2, 8);
    for (int k = 0; k < len; k++) begin
      if (k == 0) cnt = 0;
      else if (k < ramp) cnt = half * k / ramp;
      else cnt = half + longint'(int'($urandom_range(6)) - 3);
      send_tick(k == 0, cnt[CW-1:0],
                ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(10, 60));
    end
  endtask

  task automatic test_directed();
    send_tick(1'b1, 0, 0);
    send_tick(1'b0, 0, 255);
    send_tick(1'b0, 24'h7FFFFF, 0);
    send_tick(1'b0, 24'h800000, 128);
    send_tick(1'b1, 24'h800000, 255);
    send_tick(1'b0, 24'h7FFFFF, 1);
    send_tick(1'b0, -100, 40);
    send_tick(1'b0, -100, 40);
    send_tick(1'b0, -50, 40);
    send_tick(1'b0, 0, 40);
    send_tick(1'b0, 5, 40);
    send_tick(1'b0, 5, 40);
    send_tick(1'b0, 5, 10);
    send_tick(1'b0, 3, 0);
    // integral zone edge, then settle on the threshold boundary
    send_tick(1'b1, -150, 0);
    send_tick(1'b0, -149, 0);
    send_tick(1'b0, -14, 0);
    send_tick(1'b0, -15, 200);
    send_tick(1'b0, -15, 49);
    send_tick(1'b0, -15, 1);
    send_tick(1'b0, -15, 7);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_all(8388607, 1023, 1023, 1023, 127, 65535, 0, 32767);
    drive_move(15);
    repeat (5) send_noise();
    wait_drained();
    write_all(-8388608, 0, 0, 0, 0, 0, 249, -32768);
    drive_move(15);
    repeat (5) send_noise();
    wait_drained();
    write_all(1000, 1023, 0, 0, 1, 65535, 65535, -1);
    drive_move(10);
    repeat (5) send_noise();
    wait_drained();
  endtask

  task automatic randomize_config();
    int tgt, zone, settle_ms, thresh;
    case ($urandom_range(9))
      0:       tgt = 8388607;
      1:       tgt = -8388608;
      2:       tgt = int'($urandom) >>> 8;
      default: tgt = int'($urandom_range(60000)) - 30000;
    endcase
    zone = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(600);
    settle_ms = ($urandom_range(5) == 0) ? $urandom_range(249) : $urandom_range(250, 900);
    thresh = ($urandom_range(5) == 0) ? int'($urandom_range(65535)) - 32768
                                      : int'($urandom_range(300)) - 100;
    write_all(tgt, ($urandom_range(7) == 0) ? 1023 : $urandom_range(1023),
              ($urandom_range(7) == 0) ? 0 : $urandom_range(1023),
              $urandom_range(1023), ($urandom_range(7) == 0) ? 0 : $urandom_range(127),
              zone, settle_ms, thresh);
  endtask

  task automatic test_random_moves();
    int sent, len;
    for (int phase = 0; phase < 7; phase++) begin
      randomize_config();
      // one phase runs with no idling on either side
      tx_steady = (phase == 3);
      rx_steady = (phase == 3);
      sent = 0;
      while (sent < 70) begin
        if ($urandom_range(99) < 80) begin
          len = $urandom_range(10, 40);
          drive_move(len);
          sent += len;
        end else begin
          send_noise();
          sent++;
        end
      end
      wait_drained();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    stall_len = 150;
    drive_move(30);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    drive_move(10);
    wait_drained();
    repeat (10) send_tick(1'b0, encoder_count_i, $urandom_range(10, 60));
    wait_drained();
  endtask

  // timer saturation: the last add overshoots 65535 and clamps
  task automatic test_long_settle();
    write_all(0, 67, 13, 159, 127, 299, 65535, 30);
    send_tick(1'b1, 0, 0);
    repeat (265) send_tick(1'b0, 0, 250);
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_moves();
    test_backpressure();
    test_drain_pause();
    test_long_settle();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
